### sv/assert_macros.svh
// Assertion helpers for the RTL. Both take clk and rst_n from the
// scope in which they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_SAME(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### sv/rbrl_pkg.sv
package rbrl_pkg;

  // Width of the wrapping totals, the window and the rate registers (32 to 64).
  localparam int unsigned CW        = 64;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned ADD_W     = 32;
  localparam int unsigned FRAME_W   = 16;
  localparam int unsigned OUT_W     = 64;
  localparam int unsigned LIMIT_W   = 32;
  // Dividend width: the overshoot times one hundred needs seven bits more than
  // a counter, and the saturation test needs the bits above 64.
  localparam int unsigned DIV_W     = 72;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);
  localparam int unsigned PROD_W    = OUT_W + 14;

  localparam int unsigned CFG_AW    = 3;
  localparam int unsigned CFG_DW    = 32;
  localparam int unsigned CFG_IDX_W = CFG_AW - 2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = '0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPDATE,
    S_AVG_GO,
    S_AVG_WAIT,
    S_RATE_GO,
    S_RATE_WAIT,
    S_LIMIT,
    S_BO_GO,
    S_BO_WAIT,
    S_MUL,
    S_SLEEP,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    DSEL_AVG,
    DSEL_RATE,
    DSEL_BO
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     update;
    logic     div_start;
    div_sel_t div_sel;
    logic     avg_wr;
    logic     rate_wr;
    logic     lim_chk;
    logic     mul;
    logic     sleep_wr;
    logic     out_wr;
  } cmd_t;

  typedef struct packed {
    logic now_zero;
    logic gap_init_nz;
    logic gap_last_nz;
    logic over_lim;
    logic div_done;
  } status_t;

endpackage

### sv/rbrl_div.sv
module rbrl_div import rbrl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_W-1:0]   dividend,
  input  logic [LIMIT_W-1:0] divisor,
  output logic               done,
  output logic [DIV_W-1:0]   quotient
);

  // Restoring divider, one quotient bit per cycle. The dividend shifts out of
  // the top of q_r while quotient bits shift in at the bottom.
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]     q_r, q_nxt;
  logic [LIMIT_W-1:0]   rem_r, rem_nxt;
  logic [LIMIT_W-1:0]   dsr_r, dsr_nxt;
  logic [LIMIT_W:0]     rem_sh;
  logic                 fits;

  assign rem_sh = {rem_r, q_r[DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? LIMIT_W'(rem_sh - {1'b0, dsr_r}) : rem_sh[LIMIT_W-1:0];
      q_nxt   = {q_r[DIV_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

### sv/rbrl_dp.sv
module rbrl_dp import rbrl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic [TIME_W-1:0]  in_now_seconds,
  input  logic [ADD_W-1:0]   in_send_bytes_add,
  input  logic [ADD_W-1:0]   in_recv_bytes_add,
  input  logic [FRAME_W-1:0] in_send_frames_add,
  input  logic [FRAME_W-1:0] in_recv_frames_add,
  input  logic               limit_wr,
  input  logic [LIMIT_W-1:0] limit_wdata,
  output logic [LIMIT_W-1:0] limit,
  output logic               out_time_error,
  output logic               out_limit_exceeded,
  output logic [OUT_W-1:0]   out_sleep_microseconds,
  output logic [OUT_W-1:0]   out_current_recv_rate,
  output logic [OUT_W-1:0]   out_average_recv_rate,
  output logic [OUT_W-1:0]   out_recv_bytes_total,
  output logic [OUT_W-1:0]   out_send_bytes_total,
  output logic [OUT_W-1:0]   out_recv_frames_total,
  output logic [OUT_W-1:0]   out_send_frames_total
);

  // Captured word.
  logic [TIME_W-1:0]  now_r;
  logic [ADD_W-1:0]   send_add_r, recv_add_r;
  logic [FRAME_W-1:0] sfr_add_r, rfr_add_r;

  // Meter state.
  logic               started_r, started_nxt;
  logic [TIME_W-1:0]  first_r, first_nxt;
  logic [TIME_W-1:0]  latest_r, latest_nxt;
  logic [CW-1:0]      recv_tot_r, recv_tot_nxt;
  logic [CW-1:0]      send_tot_r, send_tot_nxt;
  logic [CW-1:0]      rfr_tot_r, rfr_tot_nxt;
  logic [CW-1:0]      sfr_tot_r, sfr_tot_nxt;
  logic [CW-1:0]      window_r, window_nxt;
  logic [CW-1:0]      rate_r, rate_nxt;
  logic [CW-1:0]      avg_r, avg_nxt;
  logic [LIMIT_W-1:0] limit_r, limit_nxt;

  // Per-word working registers.
  logic [TIME_W-1:0]  gap_init_r, gap_last_r;
  logic [DIV_W-1:0]   over100_r;
  logic [PROD_W-1:0]  prod_r;
  logic               qhi_r;
  logic               terr_r, exc_r;
  logic [OUT_W-1:0]   sleep_r;

  logic [TIME_W-1:0]  first_eff, latest_eff, gap_init_w, gap_last_w;
  logic [CW-1:0]      recv_add_c, over_w;
  logic [DIV_W-1:0]   over_x, over100_w;
  logic [PROD_W-1:0]  q_x, prod_w;
  logic [DIV_W-1:0]   div_dividend, div_q;
  logic [LIMIT_W-1:0] div_divisor;
  logic               div_done;

  // Before the first valid word the timers take the word's own timestamp.
  assign first_eff  = started_r ? first_r : now_r;
  assign latest_eff = started_r ? latest_r : now_r;
  assign gap_init_w = now_r - first_eff;
  assign gap_last_w = now_r - latest_eff;
  assign recv_add_c = CW'(recv_add_r);

  // Overshoot times one hundred: 64 + 32 + 4.
  assign over_w    = rate_r - CW'(limit_r);
  assign over_x    = DIV_W'(over_w);
  assign over100_w = (over_x << 6) + (over_x << 5) + (over_x << 2);

  // Percentage times ten thousand: 8192 + 1024 + 512 + 256 + 16.
  assign q_x    = PROD_W'(div_q[OUT_W-1:0]);
  assign prod_w = (q_x << 13) + (q_x << 10) + (q_x << 9) + (q_x << 8) + (q_x << 4);

  always_comb begin
    started_nxt  = started_r;
    first_nxt    = first_r;
    latest_nxt   = latest_r;
    recv_tot_nxt = recv_tot_r;
    send_tot_nxt = send_tot_r;
    rfr_tot_nxt  = rfr_tot_r;
    sfr_tot_nxt  = sfr_tot_r;
    window_nxt   = window_r;
    rate_nxt     = rate_r;
    avg_nxt      = avg_r;
    limit_nxt    = limit_r;
    if (limit_wr) begin
      limit_nxt = limit_wdata;
    end
    if (cmd.update) begin
      started_nxt  = 1'b1;
      first_nxt    = first_eff;
      latest_nxt   = now_r;
      recv_tot_nxt = recv_tot_r + recv_add_c;
      send_tot_nxt = send_tot_r + CW'(send_add_r);
      rfr_tot_nxt  = rfr_tot_r + CW'(rfr_add_r);
      sfr_tot_nxt  = sfr_tot_r + CW'(sfr_add_r);
      if (gap_last_w != '0) begin
        // An idle meter restarts its window from this word alone.
        if (rate_r == '0) begin
          window_nxt = recv_add_c;
        end
      end else begin
        window_nxt = window_r + recv_add_c;
        rate_nxt   = rate_r + recv_add_c;
      end
    end
    if (cmd.avg_wr) begin
      avg_nxt = div_q[CW-1:0];
    end
    if (cmd.rate_wr) begin
      rate_nxt   = div_q[CW-1:0];
      window_nxt = '0;
    end
    if (cmd.lim_chk) begin
      rate_nxt = CW'(limit_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r  <= 1'b0;
      first_r    <= '0;
      latest_r   <= '0;
      recv_tot_r <= '0;
      send_tot_r <= '0;
      rfr_tot_r  <= '0;
      sfr_tot_r  <= '0;
      window_r   <= '0;
      rate_r     <= '0;
      avg_r      <= '0;
      limit_r    <= '0;
    end else begin
      started_r  <= started_nxt;
      first_r    <= first_nxt;
      latest_r   <= latest_nxt;
      recv_tot_r <= recv_tot_nxt;
      send_tot_r <= send_tot_nxt;
      rfr_tot_r  <= rfr_tot_nxt;
      sfr_tot_r  <= sfr_tot_nxt;
      window_r   <= window_nxt;
      rate_r     <= rate_nxt;
      avg_r      <= avg_nxt;
      limit_r    <= limit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r      <= in_now_seconds;
      send_add_r <= in_send_bytes_add;
      recv_add_r <= in_recv_bytes_add;
      sfr_add_r  <= in_send_frames_add;
      rfr_add_r  <= in_recv_frames_add;
      terr_r     <= in_now_seconds == '0;
      exc_r      <= 1'b0;
      sleep_r    <= '0;
    end else begin
      if (cmd.lim_chk) begin
        exc_r <= 1'b1;
      end
      if (cmd.sleep_wr) begin
        sleep_r <= (qhi_r || (prod_r[PROD_W-1:OUT_W] != '0)) ? '1 : prod_r[OUT_W-1:0];
      end
    end
    if (cmd.update) begin
      gap_init_r <= gap_init_w;
      gap_last_r <= gap_last_w;
    end
    if (cmd.lim_chk) begin
      over100_r <= over100_w;
    end
    if (cmd.mul) begin
      prod_r <= prod_w;
      qhi_r  <= div_q[DIV_W-1:OUT_W] != '0;
    end
  end

  always_comb begin
    unique case (cmd.div_sel)
      DSEL_AVG: begin
        div_dividend = DIV_W'(recv_tot_r);
        div_divisor  = gap_init_r;
      end
      DSEL_RATE: begin
        div_dividend = DIV_W'(window_r);
        div_divisor  = gap_last_r;
      end
      DSEL_BO: begin
        div_dividend = over100_r;
        div_divisor  = limit_r;
      end
      default: begin
        div_dividend = DIV_W'(recv_tot_r);
        div_divisor  = gap_init_r;
      end
    endcase
  end

  rbrl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign status.now_zero    = now_r == '0;
  assign status.gap_init_nz = gap_init_r != '0;
  assign status.gap_last_nz = gap_last_r != '0;
  assign status.over_lim    = (limit_r != '0) && (rate_r > CW'(limit_r));
  assign status.div_done    = div_done;

  // Result register: a snapshot, so the next word may run while this one waits.
  always_ff @(posedge clk) begin
    if (cmd.out_wr) begin
      out_time_error         <= terr_r;
      out_limit_exceeded     <= exc_r;
      out_sleep_microseconds <= sleep_r;
      out_current_recv_rate  <= OUT_W'(rate_r);
      out_average_recv_rate  <= OUT_W'(avg_r);
      out_recv_bytes_total   <= OUT_W'(recv_tot_r);
      out_send_bytes_total   <= OUT_W'(send_tot_r);
      out_recv_frames_total  <= OUT_W'(rfr_tot_r);
      out_send_frames_total  <= OUT_W'(sfr_tot_r);
    end
  end

  assign limit = limit_r;

endmodule

### sv/rbrl_ctrl.sv
module rbrl_ctrl import rbrl_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:      if (in_valid) state_nxt = S_UPDATE;
      S_UPDATE:    state_nxt = status.now_zero ? S_FINISH : S_AVG_GO;
      S_AVG_GO:    state_nxt = status.gap_init_nz ? S_AVG_WAIT : S_RATE_GO;
      S_AVG_WAIT:  if (status.div_done) state_nxt = S_RATE_GO;
      S_RATE_GO:   state_nxt = status.gap_last_nz ? S_RATE_WAIT : S_LIMIT;
      S_RATE_WAIT: if (status.div_done) state_nxt = S_LIMIT;
      S_LIMIT:     state_nxt = status.over_lim ? S_BO_GO : S_FINISH;
      S_BO_GO:     state_nxt = S_BO_WAIT;
      S_BO_WAIT:   if (status.div_done) state_nxt = S_MUL;
      S_MUL:       state_nxt = S_SLEEP;
      S_SLEEP:     state_nxt = S_FINISH;
      S_FINISH:    if (slot_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.div_sel = DSEL_AVG;
    unique case (state_r)
      S_IDLE:      cmd.load = in_valid;
      S_UPDATE:    cmd.update = !status.now_zero;
      S_AVG_GO:    cmd.div_start = status.gap_init_nz;
      S_AVG_WAIT:  cmd.avg_wr = status.div_done;
      S_RATE_GO: begin
        cmd.div_sel   = DSEL_RATE;
        cmd.div_start = status.gap_last_nz;
      end
      S_RATE_WAIT: cmd.rate_wr = status.div_done;
      S_LIMIT:     cmd.lim_chk = status.over_lim;
      S_BO_GO: begin
        cmd.div_sel   = DSEL_BO;
        cmd.div_start = 1'b1;
      end
      S_BO_WAIT:   cmd.div_sel = DSEL_BO;
      S_MUL:       cmd.mul = 1'b1;
      S_SLEEP:     cmd.sleep_wr = 1'b1;
      S_FINISH:    cmd.out_wr = slot_free;
      default:     cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_wr) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

endmodule

### sv/recv_byte_rate_meter_limiter_unit.sv
// Receive byte rate meter and limiter.
// Input channel (in_valid/in_ready): one word per traffic event, carrying a
// timestamp in seconds and the bytes and frames sent and received since the
// previous event. Output channel (out_valid/out_ready): exactly one result
// word per input word, in order: totals, long-run average, current rate, and
// the limit flag with a back-off time in microseconds.
// The receive limit is set through the APB-style cfg_ port at offset zero;
// a limit of zero turns the check off.
// Words are processed one at a time: the next word is accepted only once the
// previous one has left the control sequence. A zero timestamp goes straight
// to the result; each time gap that is not zero adds a division, 72 steps of
// the shared one-bit-per-cycle divider, and an overshoot adds a third division
// and the multiply and saturate steps for the back-off.
// The result sits in an output register, so the next input word is taken
// while a stalled receiver holds the previous result; a further finished word
// waits inside until the output register is free.
// Reset clears all totals, timers and rates and the limit register.
`include "assert_macros.svh"

module recv_byte_rate_meter_limiter_unit import rbrl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [TIME_W-1:0]  in_now_seconds,
  input  logic [ADD_W-1:0]   in_send_bytes_add,
  input  logic [ADD_W-1:0]   in_recv_bytes_add,
  input  logic [FRAME_W-1:0] in_send_frames_add,
  input  logic [FRAME_W-1:0] in_recv_frames_add,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_time_error,
  output logic               out_limit_exceeded,
  output logic [OUT_W-1:0]   out_sleep_microseconds,
  output logic [OUT_W-1:0]   out_current_recv_rate,
  output logic [OUT_W-1:0]   out_average_recv_rate,
  output logic [OUT_W-1:0]   out_recv_bytes_total,
  output logic [OUT_W-1:0]   out_send_bytes_total,
  output logic [OUT_W-1:0]   out_recv_frames_total,
  output logic [OUT_W-1:0]   out_send_frames_total,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [CFG_AW-1:0]  cfg_paddr,
  input  logic [CFG_DW-1:0]  cfg_pwdata,
  output logic [CFG_DW-1:0]  cfg_prdata,
  output logic               cfg_pready
);

  cmd_t               cmd;
  status_t            status;
  logic               limit_wr;
  logic [LIMIT_W-1:0] limit;
  logic [CFG_IDX_W-1:0] cfg_idx;

  assign cfg_idx    = cfg_paddr[CFG_AW-1:2];
  assign cfg_pready = 1'b1;
  assign limit_wr   = cfg_psel && cfg_penable && cfg_pwrite && (cfg_idx == REG_LIMIT);

  always_comb begin
    unique case (cfg_idx)
      REG_LIMIT: cfg_prdata = CFG_DW'(limit);
      default:   cfg_prdata = '0;
    endcase
  end

  rbrl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rbrl_dp u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .status                 (status),
    .in_now_seconds         (in_now_seconds),
    .in_send_bytes_add      (in_send_bytes_add),
    .in_recv_bytes_add      (in_recv_bytes_add),
    .in_send_frames_add     (in_send_frames_add),
    .in_recv_frames_add     (in_recv_frames_add),
    .limit_wr               (limit_wr),
    .limit_wdata            (cfg_pwdata[LIMIT_W-1:0]),
    .limit                  (limit),
    .out_time_error         (out_time_error),
    .out_limit_exceeded     (out_limit_exceeded),
    .out_sleep_microseconds (out_sleep_microseconds),
    .out_current_recv_rate  (out_current_recv_rate),
    .out_average_recv_rate  (out_average_recv_rate),
    .out_recv_bytes_total   (out_recv_bytes_total),
    .out_send_bytes_total   (out_send_bytes_total),
    .out_recv_frames_total  (out_recv_frames_total),
    .out_send_frames_total  (out_send_frames_total)
  );

  // One word in flight: an accepted word closes the input for the next cycle.
  `ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  // The divider reports completion for a single cycle only.
  `ASSERT_NEXT(a_div_done_pulse, status.div_done, !status.div_done)
  // A result is only written into a free output register.
  `ASSERT_SAME(a_out_slot_free, cmd.out_wr, !out_valid || out_ready)
  // A word with a bad timestamp never reports an overshoot.
  `ASSERT_SAME(a_terr_no_limit, out_valid && out_time_error,
               !out_limit_exceeded && (out_sleep_microseconds == '0))

endmodule

### tb/recv_byte_rate_meter_limiter_unit_tb.sv
module recv_byte_rate_meter_limiter_unit_tb;
  import rbrl_pkg::*;

  localparam logic [CFG_AW-1:0] LIMIT_ADDR   = {REG_LIMIT, 2'b00};
  localparam logic [OUT_W-1:0]  COUNT_MASK   = {OUT_W{1'b1}} >> (OUT_W - CW);
  localparam int                QUIET_LIMIT  = 5000;
  localparam int                RX_HOLD_CYCLES = 600;
  // Same-second words of maximum size that build up a large rate before the
  // limit drops to one.
  localparam int                BURST_EVENTS    = 40;
  localparam int                RANDOM_CHUNKS   = 8;
  localparam int                CHUNK_EVENTS    = 98;

  typedef struct packed {
    logic [TIME_W-1:0]  now;
    logic [ADD_W-1:0]   send_add;
    logic [ADD_W-1:0]   recv_add;
    logic [FRAME_W-1:0] send_frames;
    logic [FRAME_W-1:0] recv_frames;
  } meter_event_t;

  typedef struct packed {
    logic             terr;
    logic             exceeded;
    logic [OUT_W-1:0] sleep_us;
    logic [OUT_W-1:0] rate;
    logic [OUT_W-1:0] average;
    logic [OUT_W-1:0] recv_bytes;
    logic [OUT_W-1:0] send_bytes;
    logic [OUT_W-1:0] recv_frames;
    logic [OUT_W-1:0] send_frames;
  } meter_report_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [TIME_W-1:0]  in_now_seconds;
  logic [ADD_W-1:0]   in_send_bytes_add;
  logic [ADD_W-1:0]   in_recv_bytes_add;
  logic [FRAME_W-1:0] in_send_frames_add;
  logic [FRAME_W-1:0] in_recv_frames_add;
  logic               out_valid;
  logic               out_ready;
  logic               out_time_error;
  logic               out_limit_exceeded;
  logic [OUT_W-1:0]   out_sleep_microseconds;
  logic [OUT_W-1:0]   out_current_recv_rate;
  logic [OUT_W-1:0]   out_average_recv_rate;
  logic [OUT_W-1:0]   out_recv_bytes_total;
  logic [OUT_W-1:0]   out_send_bytes_total;
  logic [OUT_W-1:0]   out_recv_frames_total;
  logic [OUT_W-1:0]   out_send_frames_total;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [CFG_AW-1:0]  cfg_paddr;
  logic [CFG_DW-1:0]  cfg_pwdata;
  logic [CFG_DW-1:0]  cfg_prdata;
  logic               cfg_pready;

  recv_byte_rate_meter_limiter_unit uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_now_seconds         (in_now_seconds),
    .in_send_bytes_add      (in_send_bytes_add),
    .in_recv_bytes_add      (in_recv_bytes_add),
    .in_send_frames_add     (in_send_frames_add),
    .in_recv_frames_add     (in_recv_frames_add),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_time_error         (out_time_error),
    .out_limit_exceeded     (out_limit_exceeded),
    .out_sleep_microseconds (out_sleep_microseconds),
    .out_current_recv_rate  (out_current_recv_rate),
    .out_average_recv_rate  (out_average_recv_rate),
    .out_recv_bytes_total   (out_recv_bytes_total),
    .out_send_bytes_total   (out_send_bytes_total),
    .out_recv_frames_total  (out_recv_frames_total),
    .out_send_frames_total  (out_send_frames_total),
    .cfg_psel               (cfg_psel),
    .cfg_penable            (cfg_penable),
    .cfg_pwrite             (cfg_pwrite),
    .cfg_paddr              (cfg_paddr),
    .cfg_pwdata             (cfg_pwdata),
    .cfg_prdata             (cfg_prdata),
    .cfg_pready             (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted state of the meter, starting from its reset values.
  logic               meter_started  = 1'b0;
  logic [TIME_W-1:0]  meter_first    = '0;
  logic [TIME_W-1:0]  meter_latest   = '0;
  logic [OUT_W-1:0]   recv_sum       = '0;
  logic [OUT_W-1:0]   send_sum       = '0;
  logic [OUT_W-1:0]   recv_frame_sum = '0;
  logic [OUT_W-1:0]   send_frame_sum = '0;
  logic [OUT_W-1:0]   window_sum     = '0;
  logic [OUT_W-1:0]   rate_cur       = '0;
  logic [OUT_W-1:0]   rate_avg       = '0;
  logic [LIMIT_W-1:0] limit_setting  = '0;

  meter_event_t  pending_events[$];
  meter_report_t expected_reports[$];

  logic [TIME_W-1:0] tb_clock;
  logic in_took;
  logic no_idle;
  int   tx_gap = 0;
  int   rx_hold = 0;
  int   stall_asks = 0;
  int   stall_seen = 0;
  int   quiet_cycles;
  int   mismatch_count = 0;
  int   reports_checked = 0;
  int   error_reports = 0;
  int   limited_reports = 0;
  int   saturated_reports = 0;

  function automatic meter_report_t advance_meter(input meter_event_t ev);
    meter_report_t rep;
    logic [TIME_W-1:0] gap_last;
    logic [TIME_W-1:0] gap_init;
    logic [OUT_W-1:0]  over;
    logic [95:0]       pct;
    logic [95:0]       usec;
    rep = '0;
    if (ev.now == '0) begin
      rep.terr = 1'b1;
    end else begin
      if (!meter_started) begin
        meter_started = 1'b1;
        meter_first = ev.now;
        meter_latest = ev.now;
      end
      send_sum = (send_sum + OUT_W'(ev.send_add)) & COUNT_MASK;
      recv_sum = (recv_sum + OUT_W'(ev.recv_add)) & COUNT_MASK;
      send_frame_sum = (send_frame_sum + OUT_W'(ev.send_frames)) & COUNT_MASK;
      recv_frame_sum = (recv_frame_sum + OUT_W'(ev.recv_frames)) & COUNT_MASK;
      gap_last = ev.now - meter_latest;
      gap_init = ev.now - meter_first;
      meter_latest = ev.now;
      if (gap_init != '0)
        rate_avg = recv_sum / OUT_W'(gap_init);
      if (gap_last != '0) begin
        // A rate of zero means the window holds nothing worth keeping.
        if (rate_cur == '0)
          window_sum = OUT_W'(ev.recv_add);
        rate_cur = window_sum / OUT_W'(gap_last);
        window_sum = '0;
      end else begin
        window_sum = (window_sum + OUT_W'(ev.recv_add)) & COUNT_MASK;
        rate_cur = (rate_cur + OUT_W'(ev.recv_add)) & COUNT_MASK;
      end
      if (limit_setting != '0 && rate_cur > OUT_W'(limit_setting)) begin
        rep.exceeded = 1'b1;
        over = rate_cur - OUT_W'(limit_setting);
        // Whole percent of overshoot, then scaled; saturates at all ones.
        pct = ({32'd0, over} * 96'd100) / 96'(limit_setting);
        usec = pct * 96'd10000;
        rep.sleep_us = (usec > {32'd0, {OUT_W{1'b1}}}) ? {OUT_W{1'b1}} : usec[OUT_W-1:0];
        rate_cur = OUT_W'(limit_setting);
      end
    end
    rep.rate = rate_cur;
    rep.average = rate_avg;
    rep.recv_bytes = recv_sum;
    rep.send_bytes = send_sum;
    rep.recv_frames = recv_frame_sum;
    rep.send_frames = send_frame_sum;
    return rep;
  endfunction

  task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                             input logic [OUT_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    meter_report_t want;
    meter_event_t  ev;
    if (!rst_n) begin
      in_took <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $error("result word with no event outstanding");
          mismatch_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("time_error", OUT_W'(want.terr), OUT_W'(out_time_error));
          check_field("limit_exceeded", OUT_W'(want.exceeded), OUT_W'(out_limit_exceeded));
          check_field("sleep_microseconds", want.sleep_us, out_sleep_microseconds);
          check_field("current_recv_rate", want.rate, out_current_recv_rate);
          check_field("average_recv_rate", want.average, out_average_recv_rate);
          check_field("recv_bytes_total", want.recv_bytes, out_recv_bytes_total);
          check_field("send_bytes_total", want.send_bytes, out_send_bytes_total);
          check_field("recv_frames_total", want.recv_frames, out_recv_frames_total);
          check_field("send_frames_total", want.send_frames, out_send_frames_total);
          reports_checked++;
          if (want.terr)
            error_reports++;
          if (want.exceeded)
            limited_reports++;
          if (want.sleep_us == {OUT_W{1'b1}})
            saturated_reports++;
        end
      end
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        ev = '{in_now_seconds, in_send_bytes_add, in_recv_bytes_add,
               in_send_frames_add, in_recv_frames_add};
        expected_reports.push_back(advance_meter(ev));
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_psel) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("recv_byte_rate_meter_limiter_unit verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // The payload holds until the word is taken; a random gap, possibly none, follows each word.
  always @(negedge clk) begin : event_driver
    meter_event_t ev;
    int roll;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_now_seconds <= '0;
      in_send_bytes_add <= '0;
      in_recv_bytes_add <= '0;
      in_send_frames_add <= '0;
      in_recv_frames_add <= '0;
    end else if (!in_valid || in_took) begin
      if (tx_gap != 0) begin
        in_valid <= 1'b0;
        tx_gap <= tx_gap - 1;
      end else if (pending_events.size() != 0) begin
        ev = pending_events.pop_front();
        in_now_seconds <= ev.now;
        in_send_bytes_add <= ev.send_add;
        in_recv_bytes_add <= ev.recv_add;
        in_send_frames_add <= ev.send_frames;
        in_recv_frames_add <= ev.recv_frames;
        in_valid <= 1'b1;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 55)
          tx_gap <= 0;
        else if (roll < 92)
          tx_gap <= $urandom_range(1, 4);
        else
          tx_gap <= $urandom_range(10, 80);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : result_receiver
    int roll;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_asks != stall_seen) begin
      stall_seen <= stall_asks;
      rx_hold <= RX_HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      out_ready <= 1'b0;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        rx_hold <= $urandom_range(10, 80);
        out_ready <= 1'b0;
      end else begin
        out_ready <= (roll >= 30);
      end
    end
  end

  // Writes the limit, then reads it back.
  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= LIMIT_ADDR;
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready)
      @(posedge clk);
    limit_setting = value;
    @(negedge clk);
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready)
      @(posedge clk);
    if (cfg_prdata !== value) begin
      $error("limit readback: expected %0h, got %0h", value, cfg_prdata);
      mismatch_count++;
    end
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic queue_event(input logic [TIME_W-1:0] now, input logic [ADD_W-1:0] send_add,
                             input logic [ADD_W-1:0] recv_add,
                             input logic [FRAME_W-1:0] send_frames,
                             input logic [FRAME_W-1:0] recv_frames);
    pending_events.push_back('{now, send_add, recv_add, send_frames, recv_frames});
  endtask

  task automatic settle();
    while (pending_events.size() != 0 || in_valid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly time that stands still or creeps forward, with jumps, steps back
  // and zero timestamps mixed in.
  task automatic queue_random_events(input int count);
    int pick;
    logic [TIME_W-1:0] now;
    logic [ADD_W-1:0]  recv_add;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)
        now = tb_clock;
      else if (pick < 70)
        now = tb_clock + 1;
      else if (pick < 82)
        now = tb_clock + $urandom_range(2, 6);
      else if (pick < 87)
        now = $urandom;
      else if (pick < 92)
        now = tb_clock - $urandom_range(1, 10);
      else
        now = '0;
      if (now != '0)
        tb_clock = now;
      case ($urandom_range(0, 9))
        0: recv_add = '0;
        1: recv_add = '1;
        2, 3: recv_add = $urandom;
        default: recv_add = $urandom_range(0, 4000);
      endcase
      queue_event(now, $urandom, recv_add, FRAME_W'($urandom_range(0, 65535)),
                  FRAME_W'($urandom_range(0, 65535)));
    end
  endtask

  initial begin : stimulus
    logic [LIMIT_W-1:0] lim;
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    no_idle = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // No limit: zero timestamps either side of the start, full-scale fields,
    // time stepping back and time wrapping past the top.
    write_limit('0);
    queue_event('0, 32'd1, 32'd2, 16'd3, 16'd4);
    queue_event(32'd5, '1, '1, '1, '1);
    queue_event(32'd5, '0, 32'd1000, '0, '0);
    queue_event(32'd7, 32'd10, 32'd4000, 16'd1, 16'd1);
    queue_event('0, '1, '1, '1, '1);
    queue_event(32'd3, '0, 32'd500, 16'd2, 16'd2);
    queue_event('1, '0, '0, '0, '0);
    queue_event(32'd1, 32'd5, 32'd5, '0, '0);
    settle();

    write_limit(32'd1000);
    queue_event(32'd2, '0, 32'd3000, 16'd1, 16'd1);
    queue_event(32'd2, '0, 32'd1500, 16'd1, 16'd1);
    queue_event(32'd3, '0, 32'd1000, '0, '0);
    queue_event(32'd4, '0, 32'd1001, '0, '0);
    queue_event(32'd4, '0, '0, '0, '0);
    settle();

    write_limit('1);
    repeat (3) queue_event(32'd6, '0, '1, '0, '0);
    settle();

    write_limit(32'd1);
    queue_event(32'd8, '0, 32'd2, '0, '0);
    queue_event(32'd8, '0, '1, '0, '0);
    queue_event(32'd9, '0, 32'd1, '0, '0);
    settle();

    // With the check off the same-second rate grows large; a limit of one
    // then gives a back-off far beyond the rate itself.
    no_idle = 1'b1;
    write_limit('0);
    repeat (BURST_EVENTS + 1) queue_event(32'd20, '0, '1, '0, '0);
    settle();
    write_limit(32'd1);
    queue_event(32'd20, '0, 32'd1, '0, '0);
    settle();

    tb_clock = 32'd20;
    for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
      case (chunk)
        0: lim = 32'd1500;
        1: lim = '0;
        2: lim = '1;
        3: lim = 32'd1;
        4: lim = $urandom_range(100, 8000);
        5: lim = $urandom;
        default: lim = $urandom_range(500, 3000);
      endcase
      no_idle = (chunk == 3 || chunk == 6);
      write_limit(lim);
      queue_random_events(CHUNK_EVENTS);
      // Long receiver stall while words keep coming, so the input backs up.
      if (chunk == 1)
        stall_asks++;
      settle();
    end

    repeat (400) @(posedge clk);
    $display("Checked %0d result words: %0d zero-timestamp, %0d over limit, %0d saturated.",
             reports_checked, error_reports, limited_reports, saturated_reports);
    $display("Limits covered zero, one, all ones and random values; one %0d-cycle stall.",
             RX_HOLD_CYCLES);
    if (mismatch_count == 0)
      $display("recv_byte_rate_meter_limiter_unit verification clean");
    else
      $display("recv_byte_rate_meter_limiter_unit verification failed");
    $finish;
  end

endmodule
